// ===== hw/rtl/bb3_pkg.sv =====
package bb3_pkg;
   localparam int MaxSide = 1024;
   localparam int SideW = 11;
   localparam int PixW = 16;
   localparam int PosW = 10;
   localparam int SumW = 20;

   typedef struct packed {
      logic [PixW-1:0] red;
      logic [PixW-1:0] green;
      logic [PixW-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic [PosW-1:0] out_row;
      logic [PosW-1:0] out_col;
      logic [PixW-1:0] avg_red;
      logic [PixW-1:0] avg_green;
      logic [PixW-1:0] avg_blue;
      logic            run_last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       write_pix;
      logic       clear_acc;
      logic       rd_en;
      logic [1:0] rd_bank;
      logic [PosW+1:0] rd_col;
      logic       acc_en;
      logic       div_start;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
   } sts_type;
endpackage

// ===== hw/rtl/bb3_if.sv =====
interface bb3_req_if;
   logic          valid;
   logic          ready;
   bb3_pkg::pix_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bb3_rsp_if;
   logic          valid;
   logic          ready;
   bb3_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bb3_datapath.sv =====
module bb3_datapath #(
   parameter int MAX_SIDE = bb3_pkg::MaxSide,
   parameter int CW = $clog2(MAX_SIDE)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bb3_pkg::cmd_type     cmd,
   input  logic [1:0]           wr_bank,
   input  logic [CW-1:0]        wr_col,
   input  bb3_pkg::pix_type     pix,
   input  logic [3:0]           divisor,
   output bb3_pkg::sts_type     sts,
   output bb3_pkg::pix_type     avg
);
   localparam int Depth = 3 * MAX_SIDE;
   localparam int AW = $clog2(Depth);
   localparam int RecipW = 25;
   localparam int RecipShift = 24;
   localparam int ProdW = bb3_pkg::SumW + RecipW;

   bb3_pkg::pix_type mem [Depth];
   bb3_pkg::pix_type rd_ff;
   logic rdv_ff;
   logic [bb3_pkg::SumW-1:0] acc_ff [3];
   logic [bb3_pkg::PixW-1:0] q_ff [3];
   logic done_ff;
   logic [RecipW-1:0] recip;
   logic [ProdW-1:0] prod [3];

   function automatic logic [AW-1:0] addr(input logic [1:0] b, input logic [CW-1:0] c);
      logic [AW+1:0] t;
      t = {{AW{1'b0}}, b} * (AW+2)'(MAX_SIDE) + {2'b00, {(AW-CW){1'b0}}, c};
      return t[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.write_pix) mem[addr(wr_bank, wr_col)] <= pix;
      if (cmd.rd_en) rd_ff <= mem[addr(cmd.rd_bank, cmd.rd_col[CW-1:0])];
   end

   // 2^24 over the window count, rounded up, exact for 20-bit sums
   always_comb begin
      unique case (divisor)
         4'd2: recip = RecipW'(8388608);
         4'd3: recip = RecipW'(5592406);
         4'd4: recip = RecipW'(4194304);
         4'd6: recip = RecipW'(2796203);
         4'd9: recip = RecipW'(1864136);
         default: recip = RecipW'(16777216);
      endcase
      for (int k = 0; k < 3; k++) prod[k] = ProdW'(acc_ff[k]) * ProdW'(recip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en & cmd.acc_en;
         done_ff <= cmd.div_start;
         if (cmd.clear_acc) begin
            for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
         end else if (rdv_ff) begin
            acc_ff[0] <= acc_ff[0] + bb3_pkg::SumW'(rd_ff.red);
            acc_ff[1] <= acc_ff[1] + bb3_pkg::SumW'(rd_ff.green);
            acc_ff[2] <= acc_ff[2] + bb3_pkg::SumW'(rd_ff.blue);
         end
         if (cmd.div_start) begin
            for (int k = 0; k < 3; k++) q_ff[k] <= prod[k][RecipShift +: bb3_pkg::PixW];
         end
      end
   end

   assign sts.div_done = done_ff;
   assign avg.red = q_ff[0];
   assign avg.green = q_ff[1];
   assign avg.blue = q_ff[2];
endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
module bb3_ctrl #(
   parameter int MAX_SIDE = bb3_pkg::MaxSide,
   parameter int CW = $clog2(MAX_SIDE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bb3_pkg::SideW-1:0]   csr_wdata,
   input  logic                        in_valid,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [bb3_pkg::PosW-1:0]    out_row,
   output logic [bb3_pkg::PosW-1:0]    out_col,
   output logic                        out_last,
   output bb3_pkg::cmd_type            cmd,
   output logic [1:0]                  wr_bank,
   output logic [CW-1:0]               wr_col,
   output logic [3:0]                  divisor,
   input  bb3_pkg::sts_type            sts
);
   localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SDrain = 3'd2,
                          SDiv = 3'd3, SOut = 3'd4, SNext = 3'd5;
   localparam int PW = bb3_pkg::PosW + 2;

   logic [2:0] state_ff, state_in;
   logic [bb3_pkg::SideW-1:0] size_ff;
   logic [PW-1:0] n, r_ff, c_ff, i_ff, j_ff, ihi_ff, jlo_ff, jhi_ff;
   logic [PW-1:0] rr_ff, cc_ff, re, ce;
   logic [1:0] rb_ff, bank_ff [3];
   logic [3:0] drain_ff;
   logic [PW-1:0] r0, c0, il, ih, jl, jh;
   logic ihi_ok;
   logic ihi_in_ok;

   always_comb begin
      n = PW'(size_ff);
      if (size_ff == '0) n = PW'(1);
      if (PW'(size_ff) > PW'(MAX_SIDE)) n = PW'(MAX_SIDE);
      re = (i_ff + PW'(2) < n) ? i_ff + PW'(2) : n - PW'(1);
      ce = (j_ff + PW'(2) < n) ? j_ff + PW'(2) : n - PW'(1);
   end

   function automatic logic [1:0] bk(input logic [1:0] b, input logic [1:0] d);
      logic [2:0] t;
      t = {1'b0, b} + {1'b0, d};
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   logic [3:0] rcnt, ccnt;
   always_comb begin
      rcnt = 4'(re - i_ff + PW'(1));
      ccnt = 4'(ce - j_ff + PW'(1));
      divisor = rcnt * ccnt;
   end

   assign in_ready = (state_ff == SIdle) && !csr_we;
   assign out_valid = (state_ff == SOut);
   assign out_row = i_ff[bb3_pkg::PosW-1:0];
   assign out_col = j_ff[bb3_pkg::PosW-1:0];
   assign out_last = (i_ff == ihi_ff) && (j_ff == jhi_ff);
   assign wr_bank = rb_ff;
   assign wr_col = c_ff[CW-1:0];

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_bank = bank_ff[2'(rr_ff - i_ff)];
      cmd.rd_col = cc_ff;
      unique case (state_ff)
         SIdle: if (in_valid && !csr_we) begin
            cmd.write_pix = 1'b1;
            cmd.clear_acc = 1'b1;
            state_in = (ihi_in_ok) ? SRead : SNext;
         end
         SRead: begin
            cmd.rd_en = 1'b1;
            cmd.acc_en = 1'b1;
            if (rr_ff == re && cc_ff == ce) state_in = SDrain;
         end
         SDrain: if (drain_ff == 4'd1) begin
            cmd.div_start = 1'b1;
            state_in = SDiv;
         end
         SDiv: if (sts.div_done) state_in = SOut;
         SOut: if (out_ready) begin
            cmd.clear_acc = 1'b1;
            state_in = out_last ? SNext : SRead;
         end
         SNext: state_in = SIdle;
         default: state_in = SIdle;
      endcase
   end

   // window ranges of the incoming pixel
   always_comb begin
      r0 = (r_ff >= n || c_ff >= n) ? '0 : r_ff;
      c0 = (r_ff >= n || c_ff >= n) ? '0 : c_ff;
      ihi_ok = 1'b1;
      if (r0 == n - PW'(1)) begin
         il = (r0 >= PW'(2)) ? r0 - PW'(2) : '0; ih = r0;
      end else if (r0 >= PW'(2)) begin
         il = r0 - PW'(2); ih = il;
      end else begin
         il = '0; ih = '0; ihi_ok = 1'b0;
      end
      if (c0 == n - PW'(1)) begin
         jl = (c0 >= PW'(2)) ? c0 - PW'(2) : '0; jh = c0;
      end else if (c0 >= PW'(2)) begin
         jl = c0 - PW'(2); jh = jl;
      end else begin
         jl = '0; jh = '0; ihi_ok = 1'b0;
      end
      ihi_in_ok = ihi_ok;
   end

   logic [1:0] rbank0;
   assign rbank0 = (r_ff >= n || c_ff >= n) ? 2'd0 : rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         size_ff <= bb3_pkg::SideW'(64);
         r_ff <= '0; c_ff <= '0; rb_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            size_ff <= csr_wdata;
            r_ff <= '0; c_ff <= '0; rb_ff <= '0;
         end
         unique case (state_ff)
            SIdle: if (in_valid && !csr_we) begin
               r_ff <= r0; c_ff <= c0; rb_ff <= rbank0;
               ihi_ff <= ih; jlo_ff <= jl; jhi_ff <= jh;
               i_ff <= il; j_ff <= jl; rr_ff <= il; cc_ff <= jl;
               // banks of rows il, il+1, il+2 relative to the written row
               bank_ff[0] <= bk(rbank0, 2'(3'd3 - 3'(r0 - il)));
               bank_ff[1] <= bk(rbank0, 2'(3'd4 - 3'(r0 - il)));
               bank_ff[2] <= bk(rbank0, 2'(3'd5 - 3'(r0 - il)));
            end
            SRead: begin
               drain_ff <= 4'd2;
               if (cc_ff == ce) begin
                  cc_ff <= j_ff; rr_ff <= rr_ff + PW'(1);
               end else cc_ff <= cc_ff + PW'(1);
            end
            SDrain: drain_ff <= drain_ff - 4'd1;
            SOut: if (out_ready && !out_last) begin
               if (j_ff == jhi_ff) begin
                  j_ff <= jlo_ff; i_ff <= i_ff + PW'(1);
                  rr_ff <= i_ff + PW'(1); cc_ff <= jlo_ff;
                  bank_ff[0] <= bank_ff[1]; bank_ff[1] <= bank_ff[2];
                  bank_ff[2] <= bank_ff[0];
               end else begin
                  j_ff <= j_ff + PW'(1); rr_ff <= i_ff; cc_ff <= j_ff + PW'(1);
               end
            end
            SNext: if (!csr_we) begin
               if (c_ff + PW'(1) >= n) begin
                  c_ff <= '0;
                  if (r_ff + PW'(1) >= n) begin
                     r_ff <= '0; rb_ff <= '0;
                  end else begin
                     r_ff <= r_ff + PW'(1); rb_ff <= bk(rb_ff, 2'd1);
                  end
               end else c_ff <= c_ff + PW'(1);
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== hw/rtl/box_blur_3x3_clipped_unit.sv =====
// 3x3 clipped box blur over a square rgb frame streamed in raster order.
// each accepted pixel is stored in a three-row buffer; a pixel that completes
// windows releases them in row-then-column order, the last one flagged. for
// each result the window pixels (1 to 9) are read from the buffer one per
// cycle, the read pipeline drains, a reciprocal multiply divides the sums and
// the result waits for the output handshake. each pixel also passes one accept
// state and one position-update state; the bottom-right corner pixel completes
// nine windows. writing csr restarts the frame.
module box_blur_3x3_clipped_unit #(
   parameter int MAX_SIDE = bb3_pkg::MaxSide
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [bb3_pkg::SideW-1:0] csr_wdata,
   bb3_req_if.sink req,
   bb3_rsp_if.source rsp
);
   localparam int CW = $clog2(MAX_SIDE);
   bb3_pkg::cmd_type cmd;
   bb3_pkg::sts_type sts;
   bb3_pkg::pix_type avg;
   logic [1:0] wr_bank;
   logic [CW-1:0] wr_col;
   logic [3:0] divisor;

   bb3_ctrl #(.MAX_SIDE(MAX_SIDE), .CW(CW)) u_ctrl (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_row(rsp.data.out_row), .out_col(rsp.data.out_col),
      .out_last(rsp.data.run_last),
      .cmd, .wr_bank, .wr_col, .divisor, .sts
   );

   bb3_datapath #(.MAX_SIDE(MAX_SIDE), .CW(CW)) u_dp (
      .clock, .reset, .cmd, .wr_bank, .wr_col, .pix(req.data),
      .divisor, .sts, .avg
   );

   assign rsp.data.avg_red = avg.red;
   assign rsp.data.avg_green = avg.green;
   assign rsp.data.avg_blue = avg.blue;
endmodule
